[rtl/pbfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette blit package
// Shared types, command and register codes, and the fixed color palette.
// ----------------------------------------------------------------------------
package pbfb_pkg;

  localparam int SCREEN_WIDTH_DEF  = 160;
  localparam int SCREEN_HEIGHT_DEF = 240;

  localparam int DIM_W      = 10;
  localparam int CMP_W      = DIM_W + 1;
  localparam int ADDR_W     = 16;
  localparam int COLOR_W    = 16;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] CMD_START   = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_PALETTE = 2'd2;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] REG_COLOR_MODE   = 3'd4;

  localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 16'h001F;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 16'hF800;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;

  typedef struct packed {
    logic [DIM_W-1:0] origin_x;
    logic [DIM_W-1:0] origin_y;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             color_mode;
  } cfg_t;

  typedef struct packed {
    logic              active;
    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic [ADDR_W-1:0] row_addr;
  } draw_t;

  function automatic logic [COLOR_W-1:0] fixed_color(input logic [1:0] idx);
    logic [COLOR_W-1:0] c;
    unique case (idx)
      2'd0:    c = COLOR_BLACK;
      2'd1:    c = COLOR_BLUE;
      2'd2:    c = COLOR_RED;
      default: c = COLOR_WHITE;
    endcase
    return c;
  endfunction

endpackage

[rtl/pbfb_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit input channel
// Valid/ready channel carrying one command word into the blitter.
// ----------------------------------------------------------------------------
interface pbfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] pixel_byte;
  logic [3:0] palette_slot;
  logic [pbfb_pkg::COLOR_W-1:0] palette_color;

  modport source (output valid, cmd, pixel_byte, palette_slot, palette_color, input ready);
  modport sink   (input valid, cmd, pixel_byte, palette_slot, palette_color, output ready);
endinterface

[rtl/pbfb_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer write channel
// Valid/ready channel carrying one framebuffer write word.
// ----------------------------------------------------------------------------
interface pbfb_out_if;
  logic valid;
  logic ready;
  logic [pbfb_pkg::ADDR_W-1:0]  pixel_address;
  logic [pbfb_pkg::COLOR_W-1:0] pixel_color;
  logic run_last;
  logic image_done;

  modport source (output valid, pixel_address, pixel_color, run_last, image_done, input ready);
  modport sink   (input valid, pixel_address, pixel_color, run_last, image_done, output ready);
endinterface

[rtl/palette_blit_to_framebuffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette blit to framebuffer
// Expands packed 4-bit or 2-bit palette pixels into RGB565 framebuffer writes.
// ----------------------------------------------------------------------------
//   Channel     Direction  Handshake                Word
//   blit_in_i   in         valid/ready              cmd, pixel_byte, palette slot/color
//   fb_out_o    out        valid/ready              address, color, run_last, image_done
//   APB         in/out     psel/penable, pready=1   origin, size, color mode
//
// A start or palette command never waits on fb_out_o. A pixel byte holds two
// pixels in 4-bit mode and four in 2-bit mode, drawn one pixel per cycle while
// fb_out_o is not stalled; it ends early when the last drawn row finishes inside it,
// and a byte that arrives while nothing is being drawn draws nothing.
// A write appears on fb_out_o, registered, in the cycle after its pixel is drawn.
// Reset clears the registers, the palette and the drawing state.
// A stalled fb_out_o holds the pixel step; the next word is taken as the
// current byte finishes its last pixel.
module palette_blit_to_framebuffer #(
  parameter int SCREEN_WIDTH  = pbfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pbfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pbfb_in_if.sink                         blit_in_i,
  pbfb_out_if.source                      fb_out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pbfb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pbfb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pbfb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int DW = pbfb_pkg::DIM_W;
  localparam int CW = pbfb_pkg::CMP_W;
  localparam int AW = pbfb_pkg::ADDR_W;
  localparam logic [CW-1:0] SW_C   = CW'(SCREEN_WIDTH);
  localparam logic [CW-1:0] SH_C   = CW'(SCREEN_HEIGHT);
  localparam logic [AW-1:0] SW_ADR = AW'(SCREEN_WIDTH);

  pbfb_pkg::cfg_t cfg;

  pbfb_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic                             h_valid_q;
  logic [1:0]                       h_cmd_q;
  logic [7:0]                       h_byte_q;
  logic [3:0]                       h_slot_q;
  logic [pbfb_pkg::COLOR_W-1:0]     h_color_q;
  logic [1:0]                       pix_q;

  pbfb_pkg::draw_t                  st_q, st_d;
  logic [DW-1:0]                    rtd_q, rtd_d;
  logic [pbfb_pkg::COLOR_W-1:0]     pal_q [16];

  logic                             out_valid_q;
  logic [AW-1:0]                    out_addr_q;
  logic [pbfb_pkg::COLOR_W-1:0]     out_color_q;
  logic                             out_last_q;
  logic                             out_done_q;

  pbfb_pkg::draw_t                  sc [4];
  logic [3:0]                       wr;
  logic [CW-1:0]                    vis_raw, visible;
  logic                             is_byte, out_free, adv, finish, out_load, later;
  logic [1:0]                       npix_m1, remaining;
  logic [3:0]                       idx4;
  logic [1:0]                       idx2;
  logic [pbfb_pkg::COLOR_W-1:0]     pix_color;
  logic                             cur_done;
  logic                             accept;
  logic                             on_screen;
  logic [CW-1:0]                    avail;
  logic [DW-1:0]                    start_rtd;
  logic [20:0]                      start_prod;

  function automatic logic pix_writes(input pbfb_pkg::draw_t s, input pbfb_pkg::cfg_t c);
    return s.active && (({1'b0, c.origin_x} + {1'b0, s.col}) < SW_C);
  endfunction

  function automatic pbfb_pkg::draw_t pix_step(input pbfb_pkg::draw_t s,
                                               input pbfb_pkg::cfg_t c,
                                               input logic [DW-1:0] rtd);
    pbfb_pkg::draw_t n;
    logic [CW-1:0]   col1;
    logic [CW-1:0]   row1;
    n    = s;
    col1 = {1'b0, s.col} + CW'(1);
    row1 = {1'b0, s.row} + CW'(1);
    if (s.active) begin
      if (col1 >= {1'b0, c.image_width}) begin
        n.col      = '0;
        n.row      = row1[DW-1:0];
        n.row_addr = s.row_addr + SW_ADR;
        if (row1[DW-1:0] >= rtd) begin
          n.active = 1'b0;
        end
      end else begin
        n.col = col1[DW-1:0];
      end
    end
    return n;
  endfunction

  // Look ahead over the rest of the byte to find its last write.
  always_comb begin
    sc[0] = st_q;
    for (int k = 0; k < 3; k++) begin
      sc[k+1] = pix_step(sc[k], cfg, rtd_q);
    end
    for (int k = 0; k < 4; k++) begin
      wr[k] = pix_writes(sc[k], cfg);
    end
  end

  always_comb begin
    vis_raw = (SW_C > {1'b0, cfg.origin_x}) ? SW_C - {1'b0, cfg.origin_x} : '0;
    visible = (vis_raw > {1'b0, cfg.image_width}) ? {1'b0, cfg.image_width} : vis_raw;
    cur_done = (({1'b0, st_q.row} + CW'(1)) == {1'b0, rtd_q})
            && (({1'b0, st_q.col} + CW'(1)) == visible);
  end

  always_comb begin
    npix_m1   = cfg.color_mode ? 2'd3 : 2'd1;
    remaining = npix_m1 - pix_q;
    later     = 1'b0;
    for (int k = 1; k < 4; k++) begin
      later = later || ((2'(k) <= remaining) && wr[k]);
    end
  end

  always_comb begin
    idx4 = pix_q[0] ? h_byte_q[3:0] : h_byte_q[7:4];
    unique case (pix_q)
      2'd0:    idx2 = h_byte_q[7:6];
      2'd1:    idx2 = h_byte_q[5:4];
      2'd2:    idx2 = h_byte_q[3:2];
      default: idx2 = h_byte_q[1:0];
    endcase
    pix_color = cfg.color_mode ? pbfb_pkg::fixed_color(idx2) : pal_q[idx4];
  end

  assign is_byte  = h_valid_q && (h_cmd_q == pbfb_pkg::CMD_BYTE) && st_q.active;
  assign out_free = !out_valid_q || fb_out_o.ready;
  assign adv      = h_valid_q && (!(is_byte && wr[0]) || out_free);
  assign finish   = adv && (!is_byte || (pix_q == npix_m1) || !sc[1].active);
  assign out_load = adv && is_byte && wr[0];

  assign blit_in_i.ready = !h_valid_q || finish;
  assign accept          = blit_in_i.valid && blit_in_i.ready;

  // Start of image: clip the row count and place the first row.
  always_comb begin
    on_screen  = ({1'b0, cfg.origin_x} < SW_C) && ({1'b0, cfg.origin_y} < SH_C);
    avail      = SH_C - {1'b0, cfg.origin_y};
    start_rtd  = ({1'b0, cfg.image_height} < avail) ? cfg.image_height : avail[DW-1:0];
    start_prod = 21'(cfg.origin_y) * 21'(SW_C);
  end

  always_comb begin
    st_d  = st_q;
    rtd_d = rtd_q;
    if (adv && is_byte) begin
      st_d = sc[1];
    end else if (adv && (h_cmd_q == pbfb_pkg::CMD_START)) begin
      st_d = '0;
      rtd_d = '0;
      if (on_screen) begin
        rtd_d       = start_rtd;
        st_d.row_addr = start_prod[AW-1:0] + AW'(cfg.origin_x);
        st_d.active = (start_rtd != '0) && (cfg.image_width != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q   <= 1'b0;
      pix_q       <= '0;
      st_q        <= '0;
      rtd_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        pal_q[i] <= '0;
      end
    end else begin
      st_q  <= st_d;
      rtd_q <= rtd_d;
      if (accept) begin
        h_valid_q <= 1'b1;
        pix_q     <= '0;
      end else if (finish) begin
        h_valid_q <= 1'b0;
      end else if (adv) begin
        pix_q <= pix_q + 2'd1;
      end
      if (adv && h_valid_q && (h_cmd_q == pbfb_pkg::CMD_PALETTE)) begin
        pal_q[h_slot_q] <= h_color_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (fb_out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      h_cmd_q   <= blit_in_i.cmd;
      h_byte_q  <= blit_in_i.pixel_byte;
      h_slot_q  <= blit_in_i.palette_slot;
      h_color_q <= blit_in_i.palette_color;
    end
    if (out_load) begin
      out_addr_q  <= st_q.row_addr + AW'(st_q.col);
      out_color_q <= pix_color;
      out_last_q  <= !later;
      out_done_q  <= cur_done;
    end
  end

  assign fb_out_o.valid         = out_valid_q;
  assign fb_out_o.pixel_address = out_addr_q;
  assign fb_out_o.pixel_color   = out_color_q;
  assign fb_out_o.run_last      = out_last_q;
  assign fb_out_o.image_done    = out_done_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_done_q |-> out_last_q)
    else $error("image_done without run_last");

  a_pix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_valid_q && !cfg.color_mode |-> pix_q[1] == 1'b0)
    else $error("pixel index past the end of a 4-bit byte");

  a_write_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> st_q.active && out_free)
    else $error("write issued while not drawing or output busy");

  a_accept_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !h_valid_q || finish)
    else $error("word taken while the current one is unfinished");

endmodule

[rtl/pbfb_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blit configuration registers
// APB register file holding the image origin, size and color mode.
// ----------------------------------------------------------------------------
module pbfb_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pbfb_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pbfb_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pbfb_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output pbfb_pkg::cfg_t                      cfg_o
);

  pbfb_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        pbfb_pkg::REG_ORIGIN_X:     cfg_d.origin_x     = pwdata[pbfb_pkg::DIM_W-1:0];
        pbfb_pkg::REG_ORIGIN_Y:     cfg_d.origin_y     = pwdata[pbfb_pkg::DIM_W-1:0];
        pbfb_pkg::REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[pbfb_pkg::DIM_W-1:0];
        pbfb_pkg::REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[pbfb_pkg::DIM_W-1:0];
        pbfb_pkg::REG_COLOR_MODE:   cfg_d.color_mode   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pbfb_pkg::REG_ORIGIN_X:     prdata[pbfb_pkg::DIM_W-1:0] = cfg_q.origin_x;
      pbfb_pkg::REG_ORIGIN_Y:     prdata[pbfb_pkg::DIM_W-1:0] = cfg_q.origin_y;
      pbfb_pkg::REG_IMAGE_WIDTH:  prdata[pbfb_pkg::DIM_W-1:0] = cfg_q.image_width;
      pbfb_pkg::REG_IMAGE_HEIGHT: prdata[pbfb_pkg::DIM_W-1:0] = cfg_q.image_height;
      pbfb_pkg::REG_COLOR_MODE:   prdata[0]                   = cfg_q.color_mode;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[dv/palette_blit_to_framebuffer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette blit checker
// Watches the command channel and the register port, predicts every
// framebuffer write word, and compares the words on the output channel
// against the predicted ones in order.
// ----------------------------------------------------------------------------
module palette_blit_to_framebuffer_checker #(
  parameter int SCREEN_WIDTH  = pbfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = pbfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pbfb_in_if                              blit_in_i,
  pbfb_out_if                             fb_out_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [pbfb_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [pbfb_pkg::APB_DATA_W-1:0] pwdata_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);

  localparam int DW  = pbfb_pkg::DIM_W;
  localparam int AW  = pbfb_pkg::ADDR_W;
  localparam int CLW = pbfb_pkg::COLOR_W;
  localparam int PAW = pbfb_pkg::APB_ADDR_W;

  localparam logic [4*CLW-1:0] TWO_BIT_COLORS =
    {pbfb_pkg::COLOR_WHITE, pbfb_pkg::COLOR_RED, pbfb_pkg::COLOR_BLUE,
     pbfb_pkg::COLOR_BLACK};

  typedef struct {
    logic [AW-1:0]  address;
    logic [CLW-1:0] color;
    logic           run_last;
    logic           image_done;
  } fb_write_t;

  pbfb_pkg::cfg_t     cfg;
  logic [CLW-1:0]     palette_mem [16];
  logic [DW-1:0]      row_cnt;
  logic [DW-1:0]      col_cnt;
  logic [DW-1:0]      rows_total;
  logic [AW-1:0]      row_base;
  logic               drawing;
  fb_write_t          expected_writes [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int        avail;
    int        npix;
    int        bits;
    int        visible;
    int        idx;
    int        produced;
    logic [CLW-1:0] color;
    fb_write_t w;

    if (!rst_ni) begin
      cfg        = '0;
      row_cnt    = '0;
      col_cnt    = '0;
      rows_total = '0;
      row_base   = '0;
      drawing    = 1'b0;
      for (int i = 0; i < 16; i++) palette_mem[i] = '0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[PAW-1:2])
          pbfb_pkg::REG_ORIGIN_X:     cfg.origin_x     = pwdata_i[DW-1:0];
          pbfb_pkg::REG_ORIGIN_Y:     cfg.origin_y     = pwdata_i[DW-1:0];
          pbfb_pkg::REG_IMAGE_WIDTH:  cfg.image_width  = pwdata_i[DW-1:0];
          pbfb_pkg::REG_IMAGE_HEIGHT: cfg.image_height = pwdata_i[DW-1:0];
          pbfb_pkg::REG_COLOR_MODE:   cfg.color_mode   = pwdata_i[0];
          default: ;
        endcase
      end

      if (blit_in_i.valid && blit_in_i.ready) begin
        case (blit_in_i.cmd)
          pbfb_pkg::CMD_START: begin
            row_cnt    = '0;
            col_cnt    = '0;
            rows_total = '0;
            row_base   = '0;
            drawing    = 1'b0;
            if (cfg.origin_x < SCREEN_WIDTH && cfg.origin_y < SCREEN_HEIGHT) begin
              avail      = SCREEN_HEIGHT - int'(cfg.origin_y);
              rows_total = (int'(cfg.image_height) < avail) ? cfg.image_height
                                                            : DW'(avail);
              row_base   = AW'(int'(cfg.origin_y) * SCREEN_WIDTH
                               + int'(cfg.origin_x));
              drawing    = (rows_total != 0) && (cfg.image_width != 0);
            end
          end
          pbfb_pkg::CMD_PALETTE:
            palette_mem[blit_in_i.palette_slot] = blit_in_i.palette_color;
          pbfb_pkg::CMD_BYTE: begin
            npix     = cfg.color_mode ? 4 : 2;
            bits     = cfg.color_mode ? 2 : 4;
            visible  = (SCREEN_WIDTH > int'(cfg.origin_x))
                       ? SCREEN_WIDTH - int'(cfg.origin_x) : 0;
            if (visible > int'(cfg.image_width)) visible = cfg.image_width;
            produced = 0;
            for (int p = 0; p < npix && drawing; p++) begin
              idx = (int'(blit_in_i.pixel_byte) >> (8 - bits * (p + 1)))
                    & ((1 << bits) - 1);
              color = cfg.color_mode ? TWO_BIT_COLORS[idx*CLW +: CLW]
                                     : palette_mem[idx];
              if (int'(cfg.origin_x) + int'(col_cnt) < SCREEN_WIDTH) begin
                w.address    = AW'(int'(row_base) + int'(col_cnt));
                w.color      = color;
                w.run_last   = 1'b0;
                w.image_done = (int'(row_cnt) + 1 == int'(rows_total))
                               && (int'(col_cnt) + 1 == visible);
                expected_writes.push_back(w);
                produced++;
              end
              if (int'(col_cnt) + 1 >= int'(cfg.image_width)) begin
                col_cnt  = '0;
                row_cnt  = row_cnt + 1'b1;
                row_base = row_base + AW'(SCREEN_WIDTH);
                if (row_cnt >= rows_total) drawing = 1'b0;
              end else begin
                col_cnt = col_cnt + 1'b1;
              end
            end
            if (produced > 0) expected_writes[expected_writes.size()-1].run_last = 1'b1;
          end
          default: ;
        endcase
      end

      if (fb_out_i.valid && fb_out_i.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch($sformatf("unexpected write word, address %0d color %h",
                                    fb_out_i.pixel_address, fb_out_i.pixel_color));
        end else begin
          w = expected_writes.pop_front();
          if (fb_out_i.pixel_address !== w.address)
            report_mismatch($sformatf("pixel_address %0d, predicted %0d",
                                      fb_out_i.pixel_address, w.address));
          if (fb_out_i.pixel_color !== w.color)
            report_mismatch($sformatf("pixel_color %h at %0d, predicted %h",
                                      fb_out_i.pixel_color, w.address, w.color));
          if (fb_out_i.run_last !== w.run_last)
            report_mismatch($sformatf("run_last %b at %0d, predicted %b",
                                      fb_out_i.run_last, w.address, w.run_last));
          if (fb_out_i.image_done !== w.image_done)
            report_mismatch($sformatf("image_done %b at %0d, predicted %b",
                                      fb_out_i.image_done, w.address, w.image_done));
        end
      end
    end
    pending_o = expected_writes.size();
  end

endmodule

[dv/palette_blit_to_framebuffer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette blit testbench
// Drives commands and register writes into the blitter under several idle
// and stall mixes: a directed pass over clipping, off-screen origins and both
// color modes, then random images with noise and restarts in between.
// ----------------------------------------------------------------------------
module palette_blit_to_framebuffer_tb;

  localparam int          SW           = pbfb_pkg::SCREEN_WIDTH_DEF;
  localparam int          SH           = pbfb_pkg::SCREEN_HEIGHT_DEF;
  localparam logic [1:0]  CMD_START    = pbfb_pkg::CMD_START;
  localparam logic [1:0]  CMD_BYTE     = pbfb_pkg::CMD_BYTE;
  localparam logic [1:0]  CMD_PALETTE  = pbfb_pkg::CMD_PALETTE;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          ITEM_TARGET  = 500;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [pbfb_pkg::APB_ADDR_W-1:0] paddr;
  logic [pbfb_pkg::APB_DATA_W-1:0] pwdata;
  logic [pbfb_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;
  int unsigned                     pending_writes;
  int unsigned                     mismatches;
  int unsigned                     cycle_count = 0;
  int unsigned                     send_idle_pct = 0;
  int unsigned                     sink_stall_pct = 0;

  pbfb_in_if  blit_in ();
  pbfb_out_if fb_out ();

  palette_blit_to_framebuffer #(
    .SCREEN_WIDTH (SW),
    .SCREEN_HEIGHT(SH)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .blit_in_i(blit_in),
    .fb_out_o (fb_out),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  palette_blit_to_framebuffer_checker #(
    .SCREEN_WIDTH (SW),
    .SCREEN_HEIGHT(SH)
  ) fb_check (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .blit_in_i(blit_in),
    .fb_out_i (fb_out),
    .psel_i   (psel),
    .penable_i(penable),
    .pwrite_i (pwrite),
    .pready_i (pready),
    .paddr_i  (paddr),
    .pwdata_i (pwdata),
    .pending_o(pending_writes),
    .errors_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    fb_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      fb_out.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_word(input logic [1:0] cmd, input logic [7:0] pixel_byte,
                           input logic [3:0] slot, input logic [15:0] color);
    while ($urandom_range(99) < send_idle_pct) begin
      blit_in.valid <= 1'b0;
      @(negedge clk_i);
    end
    blit_in.valid         <= 1'b1;
    blit_in.cmd           <= cmd;
    blit_in.pixel_byte    <= pixel_byte;
    blit_in.palette_slot  <= slot;
    blit_in.palette_color <= color;
    @(posedge clk_i);
    while (!blit_in.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    blit_in.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_writes != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] reg_idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic configure(input int ox, input int oy, input int w, input int h,
                           input int mode);
    wait_for_drain();
    apb_write(pbfb_pkg::REG_ORIGIN_X, ox);
    apb_write(pbfb_pkg::REG_ORIGIN_Y, oy);
    apb_write(pbfb_pkg::REG_IMAGE_WIDTH, w);
    apb_write(pbfb_pkg::REG_IMAGE_HEIGHT, h);
    apb_write(pbfb_pkg::REG_COLOR_MODE, mode);
  endtask

  initial begin
    int          ox;
    int          oy;
    int          w;
    int          h;
    int          mode;
    int          rows;
    int          nbytes;
    int          scene;
    int unsigned pick;
    int unsigned items_sent;

    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    blit_in.valid         = 1'b0;
    blit_in.cmd           = CMD_START;
    blit_in.pixel_byte    = '0;
    blit_in.palette_slot  = '0;
    blit_in.palette_color = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Bytes before any start and the unused command draw nothing.
    send_word(CMD_BYTE, 8'hFF, 4'h0, 16'h0000);
    send_word(CMD_UNUSED, 8'hA5, 4'hF, 16'hFFFF);
    send_word(CMD_PALETTE, 8'h00, 4'h0, 16'hFFFF);
    send_word(CMD_PALETTE, 8'h00, 4'hF, 16'h5A5A);
    send_word(CMD_PALETTE, 8'h00, 4'h5, 16'hA5A5);

    configure(0, 0, 4, 2, 0);
    send_word(CMD_START, 8'h00, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'h0F, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hF5, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'h50, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hFF, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hFF, 4'h0, 16'h0000);

    // Right-edge and bottom clipping together in the fixed palette mode.
    configure(156, 238, 8, 5, 1);
    send_word(CMD_START, 8'h00, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'h1B, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hE4, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hFF, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'h00, 4'h0, 16'h0000);

    configure(SW - 1, SH - 1, 1, 1, 0);
    send_word(CMD_START, 8'h00, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hF0, 4'h0, 16'h0000);

    configure(SW, 0, 4, 4, 0);
    send_word(CMD_START, 8'h00, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'h55, 4'h0, 16'h0000);

    configure(1023, 1023, 1023, 1023, 1);
    send_word(CMD_START, 8'h00, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hAA, 4'h0, 16'h0000);

    configure(0, 0, 1023, 1023, 0);
    send_word(CMD_START, 8'h00, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'h5F, 4'h0, 16'h0000);
    send_word(CMD_BYTE, 8'hF5, 4'h0, 16'h0000);

    items_sent = 0;
    scene      = 0;
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(9);
      ox = (pick == 0) ? 0 : (pick < 3) ? SW - 1 - $urandom_range(7)
         : (pick == 3) ? $urandom_range(1023, SW) : $urandom_range(SW - 1);
      pick = $urandom_range(9);
      oy = (pick == 0) ? 0 : (pick < 3) ? SH - 1 - $urandom_range(7)
         : (pick == 3) ? $urandom_range(1023, SH) : $urandom_range(SH - 1);
      pick = $urandom_range(19);
      w  = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(200, 17) : $urandom_range(16, 1);
      h  = ($urandom_range(19) == 0) ? 0 : $urandom_range(6, 1);
      mode = $urandom_range(1);

      configure(ox, oy, w, h, mode);
      // The configure call above also leaves the sender paused until every
      // predicted word has come back, so the idle mix switches on a clean edge.
      case (scene % 4)
        0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin send_idle_pct = 74; sink_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  sink_stall_pct = 74; end
        default: begin send_idle_pct = 27; sink_stall_pct = 27; end
      endcase

      repeat ($urandom_range(3)) begin
        send_word(CMD_PALETTE, 8'($urandom), 4'($urandom), 16'($urandom));
        items_sent++;
      end
      send_word(CMD_START, 8'($urandom), 4'($urandom), 16'($urandom));
      items_sent++;

      rows = 0;
      if (ox < SW && oy < SH) rows = (h < SH - oy) ? h : SH - oy;
      nbytes = (w * rows + (mode ? 3 : 1)) / (mode ? 4 : 2) + $urandom_range(2);
      if (nbytes > 40) nbytes = 40;

      for (int b = 0; b < nbytes; b++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          send_word(CMD_PALETTE, 8'($urandom), 4'($urandom), 16'($urandom));
        end else if (pick < 6) begin
          send_word(CMD_UNUSED, 8'($urandom), 4'($urandom), 16'($urandom));
        end else if (pick < 8) begin
          send_word(CMD_START, 8'($urandom), 4'($urandom), 16'($urandom));
        end
        send_word(CMD_BYTE, 8'($urandom), 4'($urandom), 16'($urandom));
        items_sent++;
      end
      scene++;
    end

    wait_for_drain();
    if (mismatches == 0 && pending_writes == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
